[hw/rtl/mtt_pkg.sv]
// mtt_pkg: item codes, sequencer codes and the microcode program of the matrix tracker
// no dependencies; used by matrix_transform_tracker_top and mtt_checker

package mtt_pkg;

	// item kinds
	localparam logic [1:0] KIND_IDENTITY  = 2'd0;
	localparam logic [1:0] KIND_STAGE     = 2'd1;
	localparam logic [1:0] KIND_TRANSLATE = 2'd2;
	localparam logic [1:0] KIND_READ      = 2'd3;

	// register index (word address bit)
	localparam logic CFG_IDX_ENABLE = 1'b0;

	// sequencer ops
	localparam logic [1:0] SEQ_DISPATCH = 2'd0;
	localparam logic [1:0] SEQ_NEXT     = 2'd1;
	localparam logic [1:0] SEQ_LOOP     = 2'd2;
	localparam logic [1:0] SEQ_WAIT     = 2'd3;

	// program steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] S_IDLE     = 3'd0;
	localparam logic [STEP_W-1:0] S_RD_ISSUE = 3'd1;
	localparam logic [STEP_W-1:0] S_RD_LOAD  = 3'd2;
	localparam logic [STEP_W-1:0] S_ID_WR    = 3'd3;
	localparam logic [STEP_W-1:0] S_MUL      = 3'd4;
	localparam logic [STEP_W-1:0] S_DRAIN1   = 3'd5;
	localparam logic [STEP_W-1:0] S_DRAIN2   = 3'd6;
	localparam logic [STEP_W-1:0] S_WB       = 3'd7;

	typedef struct packed {
		logic [1:0]        op;
		logic [STEP_W-1:0] target;
		logic [3:0]        last;
		logic              mac;
		logic              wr_ident;
		logic              wr_res;
		logic              out_load;
	} ctrl_t;

	function automatic ctrl_t mtt_program(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{op: SEQ_NEXT, target: S_IDLE, last: 4'd0, mac: 1'b0,
			wr_ident: 1'b0, wr_res: 1'b0, out_load: 1'b0};
		unique case (step)
			S_IDLE: begin
				w.op = SEQ_DISPATCH;
			end
			S_RD_ISSUE: begin
				w.target = S_RD_LOAD;
			end
			S_RD_LOAD: begin
				w.op       = SEQ_WAIT;
				w.out_load = 1'b1;
			end
			S_ID_WR: begin
				w.op       = SEQ_LOOP;
				w.last     = 4'd3;
				w.wr_ident = 1'b1;
			end
			S_MUL: begin
				w.op     = SEQ_LOOP;
				w.last   = 4'd15;
				w.target = S_DRAIN1;
				w.mac    = 1'b1;
			end
			S_DRAIN1: begin
				w.target = S_DRAIN2;
			end
			S_DRAIN2: begin
				w.target = S_WB;
			end
			S_WB: begin
				w.op     = SEQ_LOOP;
				w.last   = 4'd3;
				w.wr_res = 1'b1;
			end
			default: begin
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/mtt_ram.sv]
// mtt_ram: generic single write port, single read port ram with registered read
// no dependencies

module mtt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/matrix_transform_tracker_top.sv]
// matrix_transform_tracker_top: column-major 4x4 fixed point matrix tracker
// depends on mtt_pkg and mtt_ram
// read: request captured, store row read, result registered; no new item until it loads
// identity: writes the four columns in turn; staging a column 0..2 is written on accept
// multiply or translate: mac steps read one ram column per cycle into four multipliers
// reset clears control, the stage buffer and the row valid bits; matrices read as zero

module matrix_transform_tracker_top import mtt_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int NUM_MATRICES = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         kind,
	input  logic               matrix_select,
	input  logic [1:0]         column,
	input  logic signed [31:0] elem_0,
	input  logic signed [31:0] elem_1,
	input  logic signed [31:0] elem_2,
	input  logic signed [31:0] elem_3,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         read_column,
	output logic signed [31:0] res_0,
	output logic signed [31:0] res_1,
	output logic signed [31:0] res_2,
	output logic signed [31:0] res_3
);

	localparam int ROWS  = NUM_MATRICES * 4;
	localparam int RW    = $clog2(ROWS);
	localparam int SW    = 64 - FRAC_BITS;
	localparam int ACC_W = SW + 2;
	localparam logic MULTI = (NUM_MATRICES > 1);
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	function automatic logic [RW-1:0] row_of(input logic s, input logic [1:0] c);
		return RW'({29'd0, s, c});
	endfunction

	logic               tracking_enable_q;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [3:0]         k_q, k_d;
	ctrl_t              cw;
	logic               accept;
	logic               sel_ok_in, sel_ok_q;
	logic               out_block, out_load;

	logic [1:0]         kind_q;
	logic               sel_q;
	logic [1:0]         col_q;
	logic [31:0]        elem_q [4];
	logic [31:0]        elem_in [4];
	logic [31:0]        stg_q [16];

	logic               we;
	logic [RW-1:0]      waddr, raddr;
	logic [127:0]       wdata, rdata;
	logic [ROWS-1:0]    row_valid_q;
	logic               rvalid_q;
	logic [31:0]        a_row [4];

	logic [31:0]        b_sel;
	logic               mac_s1, first_s1, last_s1;
	logic [1:0]         ccol_s1;
	logic signed [31:0] b_s1;
	logic               mac_s2, first_s2, last_s2;
	logic [1:0]         ccol_s2;
	logic signed [63:0] prod_s2 [4];
	logic [ACC_W-1:0]   acc_q [4];
	logic [ACC_W-1:0]   sum [4];
	logic [31:0]        sat [4];
	logic [31:0]        res_col_q [4][4];

	logic               result_valid_q;
	logic [1:0]         read_column_q;
	logic [31:0]        res_q [4];

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_ENABLE) ? {31'd0, tracking_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_ENABLE) begin
			tracking_enable_q <= pwdata[0];
		end
	end

	// sequencer
	assign cw         = mtt_program(step_q);
	assign item_stall = (step_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign sel_ok_in  = !matrix_select || MULTI;
	assign sel_ok_q   = !sel_q || MULTI;
	assign out_block  = result_valid_q && result_stall;
	assign out_load   = cw.out_load && !out_block;

	always_comb begin
		step_d = step_q;
		k_d    = k_q;
		unique case (cw.op)
			SEQ_DISPATCH: begin
				if (accept) begin
					if (kind == KIND_READ) begin
						step_d = S_RD_ISSUE;
					end else if (tracking_enable_q && sel_ok_in) begin
						case (kind)
							KIND_IDENTITY:  step_d = S_ID_WR;
							KIND_TRANSLATE: step_d = S_MUL;
							KIND_STAGE:     step_d = (column == 2'd3) ? S_MUL : S_IDLE;
							default:        step_d = S_IDLE;
						endcase
					end
				end
			end
			SEQ_NEXT: begin
				step_d = cw.target;
			end
			SEQ_LOOP: begin
				if (k_q == cw.last) begin
					k_d    = 4'd0;
					step_d = cw.target;
				end else begin
					k_d = k_q + 4'd1;
				end
			end
			SEQ_WAIT: begin
				if (!out_block) begin
					step_d = cw.target;
				end
			end
			default: begin
				step_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			k_q    <= 4'd0;
		end else begin
			step_q <= step_d;
			k_q    <= k_d;
		end
	end

	// request capture
	assign elem_in[0] = elem_0;
	assign elem_in[1] = elem_1;
	assign elem_in[2] = elem_2;
	assign elem_in[3] = elem_3;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			sel_q  <= matrix_select;
			col_q  <= column;
			for (int r = 0; r < 4; r++) begin
				elem_q[r] <= elem_in[r];
			end
		end
	end

	// stage buffer, index row + 4*column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				stg_q[i] <= 32'd0;
			end
		end else if (accept && kind == KIND_STAGE && tracking_enable_q && sel_ok_in) begin
			for (int r = 0; r < 4; r++) begin
				stg_q[{column, r[1:0]}] <= elem_in[r];
			end
		end
	end

	// matrix store, one row per matrix column
	assign raddr = row_of(sel_q, cw.mac ? k_q[1:0] : col_q);
	assign waddr = row_of(sel_q, k_q[1:0]);
	assign we    = cw.wr_ident || cw.wr_res;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			if (cw.wr_ident) begin
				wdata[32*r +: 32] = (k_q[1:0] == r[1:0]) ? ONE : 32'd0;
			end else begin
				wdata[32*r +: 32] = res_col_q[k_q[1:0]][r];
			end
		end
	end

	mtt_ram #(
		.WIDTH(128),
		.DEPTH(ROWS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= row_valid_q[raddr];
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			a_row[r] = rvalid_q ? rdata[32*r +: 32] : 32'd0;
		end
	end

	// right-hand operand element (row k[1:0], column k[3:2])
	always_comb begin
		if (kind_q == KIND_TRANSLATE) begin
			if (k_q[3:2] != 2'd3) begin
				b_sel = (k_q[1:0] == k_q[3:2]) ? ONE : 32'd0;
			end else begin
				b_sel = (k_q[1:0] == 2'd3) ? ONE : elem_q[k_q[1:0]];
			end
		end else begin
			b_sel = stg_q[k_q];
		end
	end

	// mac pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= cw.mac;
			mac_s2 <= mac_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q[1:0] == 2'd0);
		last_s1  <= (k_q[1:0] == 2'd3);
		ccol_s1  <= k_q[3:2];
		b_s1     <= b_sel;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		ccol_s2  <= ccol_s1;
		for (int r = 0; r < 4; r++) begin
			prod_s2[r] <= $signed(a_row[r]) * b_s1;
		end
	end

	// floor shift, accumulate, saturate
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = {{2{prod_s2[r][63]}}, prod_s2[r][63:FRAC_BITS]}
				+ (first_s2 ? {ACC_W{1'b0}} : acc_q[r]);
			if (sum[r][ACC_W-1:31] == '0 || sum[r][ACC_W-1:31] == '1) begin
				sat[r] = sum[r][31:0];
			end else begin
				sat[r] = sum[r][ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mac_s2) begin
			for (int r = 0; r < 4; r++) begin
				acc_q[r] <= sum[r];
				if (last_s2) begin
					res_col_q[ccol_s2][r] <= sat[r];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_column_q <= col_q;
			for (int r = 0; r < 4; r++) begin
				res_q[r] <= sel_ok_q ? a_row[r] : 32'd0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign read_column  = read_column_q;
	assign res_0        = res_q[0];
	assign res_1        = res_q[1];
	assign res_2        = res_q[2];
	assign res_3        = res_q[3];

endmodule

[hw/rtl/mtt_checker.sv]
// mtt_checker: port level assertions for matrix_transform_tracker_top, with its bind
// depends on mtt_pkg

module mtt_checker import mtt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [1:0]  kind,
	input logic [1:0]  column,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  read_column,
	input logic [31:0] res_0
);

	// stalled result stays
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(res_0) && $stable(read_column))
		else $error("stalled result dropped or changed");

	// read request taken while the output is empty returns its column
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && kind == KIND_READ && !result_valid
		|-> ##3 result_valid && read_column == $past(column, 3))
		else $error("read result missing or wrong column");

	// results only come out of a read in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without a read in progress");

	// a taken read keeps the input side busy
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && kind == KIND_READ |=> item_stall ##1 item_stall)
		else $error("read request not held busy");

endmodule

bind matrix_transform_tracker_top mtt_checker u_mtt_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for matrix_transform_tracker_top, modelview and projection tracking
// depends on mtt_pkg and the rtl of matrix_transform_tracker_top; predicts every column read

module tb import mtt_pkg::*; ();

	localparam int FRAC = 16;
	localparam logic [31:0] ONE = 32'd1 << FRAC;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [1:0]       column;
		logic [3:0][31:0] rows;
	} col_read_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid;
	logic               item_stall;
	logic [1:0]         kind;
	logic               matrix_select;
	logic [1:0]         column;
	logic signed [31:0] elem_0;
	logic signed [31:0] elem_1;
	logic signed [31:0] elem_2;
	logic signed [31:0] elem_3;
	logic               result_valid;
	logic               result_stall;
	logic [1:0]         read_column;
	logic signed [31:0] res_0;
	logic signed [31:0] res_1;
	logic signed [31:0] res_2;
	logic signed [31:0] res_3;

	logic [15:0][31:0] tracked_mats [2];
	logic [15:0][31:0] staged_cols;
	logic              track_en;
	col_read_t         pending_reads[$];

	int          mismatches = 0;
	int          items_done = 0;
	int          stall_left = 0;
	int          hold_req = 0;
	bit          quiet = 1'b0;
	int unsigned cycle_count = 0;

	matrix_transform_tracker_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [15:0][31:0] identity_matrix();
		logic [15:0][31:0] m;
		m = '0;
		m[0] = ONE;
		m[5] = ONE;
		m[10] = ONE;
		m[15] = ONE;
		return m;
	endfunction

	function automatic logic [31:0] saturate32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic void post_multiply(input logic sel, input logic [15:0][31:0] rhs);
		logic [15:0][31:0] prod;
		longint acc;
		longint a;
		longint b;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				acc = 0;
				for (int i = 0; i < 4; i++) begin
					a = $signed(tracked_mats[sel][r + 4 * i]);
					b = $signed(rhs[i + 4 * c]);
					acc += (a * b) >>> FRAC;
				end
				prod[r + 4 * c] = saturate32(acc);
			end
		end
		tracked_mats[sel] = prod;
	endfunction

	function automatic void apply_request(input logic [1:0] k, input logic sel,
			input logic [1:0] col, input logic [3:0][31:0] el);
		col_read_t rd;
		logic [15:0][31:0] shift_mat;
		if (k == KIND_READ) begin
			rd.column = col;
			for (int r = 0; r < 4; r++)
				rd.rows[r] = tracked_mats[sel][r + 4 * col];
			pending_reads.push_back(rd);
			return;
		end
		if (!track_en)
			return;
		case (k)
			KIND_IDENTITY: begin
				tracked_mats[sel] = identity_matrix();
			end
			KIND_STAGE: begin
				for (int r = 0; r < 4; r++)
					staged_cols[r + 4 * col] = el[r];
				if (col == 2'd3)
					post_multiply(sel, staged_cols);
			end
			default: begin
				shift_mat = identity_matrix();
				shift_mat[12] = el[0];
				shift_mat[13] = el[1];
				shift_mat[14] = el[2];
				post_multiply(sel, shift_mat);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	always @(posedge clk) begin
		col_read_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("read result with no request pending", {30'b0, read_column}, '0);
			end else begin
				want = pending_reads.pop_front();
				if (read_column !== want.column)
					report_mismatch("read_column", {30'b0, read_column}, {30'b0, want.column});
				if (res_0 !== want.rows[0])
					report_mismatch("res_0", res_0, want.rows[0]);
				if (res_1 !== want.rows[1])
					report_mismatch("res_1", res_1, want.rows[1]);
				if (res_2 !== want.rows[2])
					report_mismatch("res_2", res_2, want.rows[2]);
				if (res_3 !== want.rows[3])
					report_mismatch("res_3", res_3, want.rows[3]);
			end
		end
	end

	// ---------------------------------------------------------------- idling

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side stall, long holds are requested through hold_req
	always @(posedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if (quiet || $urandom_range(0, 99) < 65) begin
			result_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			result_stall <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_item(input logic [1:0] k, input logic sel, input logic [1:0] col,
			input logic [3:0][31:0] el);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind          <= k;
		matrix_select <= sel;
		column        <= col;
		elem_0        <= el[0];
		elem_1        <= el[1];
		elem_2        <= el[2];
		elem_3        <= el[3];
		item_valid    <= 1'b1;
		do @(posedge clk); while (item_stall);
		apply_request(k, sel, col, el);
		items_done++;
	endtask

	task automatic send_read(input logic sel, input logic [1:0] col);
		send_item(KIND_READ, sel, col, '0);
	endtask

	task automatic settle_outputs();
		item_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_tracking(input logic value);
		settle_outputs();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {CFG_IDX_ENABLE, 2'b00};
		pwdata  <= {31'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		track_en = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [31:0] rand_elem();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'h0;
				1: return ONE;
				2: return -ONE;
				default: return ONE >> 1;
			endcase
		end
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'hffff_ffff;
				default: return 32'h1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [3:0][31:0] rand_column();
		logic [3:0][31:0] c;
		for (int r = 0; r < 4; r++)
			c[r] = rand_elem();
		return c;
	endfunction

	// ---------------------------------------------------------------- tests

	// updates are dropped while disabled, reads still return the cleared store
	task automatic test_disabled_at_reset();
		send_item(KIND_IDENTITY, 1'b0, 2'd0, '0);
		send_item(KIND_STAGE, 1'b1, 2'd3, {4{ONE}});
		send_read(1'b0, 2'd0);
		send_read(1'b1, 2'd3);
	endtask

	task automatic test_identity_load();
		send_item(KIND_IDENTITY, 1'b0, 2'd0, '0);
		send_item(KIND_IDENTITY, 1'b1, 2'd2, '0);
		send_read(1'b0, 2'd0);
		send_read(1'b0, 2'd1);
		send_read(1'b1, 2'd2);
		send_read(1'b1, 2'd3);
	endtask

	// identity times extremes, then a lone column 3 reuses stale columns and saturates
	task automatic test_multiply_extremes();
		send_item(KIND_STAGE, 1'b0, 2'd0, {ONE, 32'h0, 32'h8000_0000, 32'h7fff_ffff});
		send_item(KIND_STAGE, 1'b0, 2'd1, {32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000});
		send_item(KIND_STAGE, 1'b0, 2'd2, {32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1});
		send_item(KIND_STAGE, 1'b0, 2'd3, {32'h7fff_ffff, 32'h8000_0000, 32'h0, ONE});
		send_read(1'b0, 2'd0);
		send_read(1'b0, 2'd2);
		send_item(KIND_STAGE, 1'b0, 2'd3, {32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, -ONE});
		send_read(1'b0, 2'd1);
		send_read(1'b0, 2'd3);
	endtask

	// elem_3 carries junk that must not matter
	task automatic test_translate();
		send_item(KIND_TRANSLATE, 1'b1, 2'd1, {32'hdead_beef, -ONE, 32'h8000_0000, 32'h7fff_ffff});
		send_read(1'b1, 2'd3);
		send_read(1'b1, 2'd0);
	endtask

	task automatic test_random_traffic(input int target);
		int stop;
		int pick;
		int first;
		logic sel;
		logic [1:0] col;
		stop = items_done + target;
		while (items_done < stop) begin
			sel = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_item(KIND_IDENTITY, sel, 2'($urandom_range(0, 3)), rand_column());
			end else if (pick < 55) begin
				first = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) begin
					col = 2'((first + i) % 3);
					if ($urandom_range(0, 4) != 0)
						send_item(KIND_STAGE, sel, col, rand_column());
				end
				send_item(KIND_STAGE, sel, 2'd3, rand_column());
			end else if (pick < 70) begin
				send_item(KIND_TRANSLATE, sel, 2'($urandom_range(0, 3)), rand_column());
			end else if (pick < 85) begin
				send_item(2'($urandom_range(0, 3)), 1'($urandom), 2'($urandom),
					{$urandom, $urandom, $urandom, $urandom});
			end
			repeat ($urandom_range(1, 4))
				send_read(sel, 2'($urandom_range(0, 3)));
		end
	endtask

	// output held off long enough for the block to back up into its input
	task automatic test_backpressure();
		quiet = 1'b1;
		hold_req = 300;
		repeat (40)
			send_read(1'($urandom), 2'($urandom));
		quiet = 1'b0;
		settle_outputs();
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_valid    = 1'b0;
		kind          = KIND_IDENTITY;
		matrix_select = 1'b0;
		column        = '0;
		elem_0        = '0;
		elem_1        = '0;
		elem_2        = '0;
		elem_3        = '0;
		result_stall  = 1'b0;
		tracked_mats[0] = '0;
		tracked_mats[1] = '0;
		staged_cols   = '0;
		track_en      = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_at_reset();
		set_tracking(1'b1);
		test_identity_load();
		test_multiply_extremes();
		test_translate();
		test_random_traffic(550);
		test_backpressure();
		set_tracking(1'b0);
		test_random_traffic(150);
		set_tracking(1'b1);
		quiet = 1'b1;
		test_random_traffic(150);
		quiet = 1'b0;
		test_random_traffic(400);
		settle_outputs();

		if (mismatches == 0 && pending_reads.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
